// ===== src/kda_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kda_pkg
// Shared types and constants for the key debounce / auto-repeat block.
// ----------------------------------------------------------------------------
package kda_pkg;

    localparam int RAW_W          = 10;   // raw_switches field width
    localparam int SWITCH_INDEX_W = 4;    // switch_index field width
    localparam int COUNT_W        = 32;   // repeat ordinal, frame numbers
    localparam int CFG_W          = 16;   // widest configuration register
    localparam int CFG_INDEX_W    = 1;
    localparam int MAX_RESULTS    = 10;   // actions per frame at most
    localparam int RESULT_CNT_W   = $clog2(MAX_RESULTS);
    localparam int DIV_STEPS      = 32;   // one quotient bit per step
    localparam int STEP_W         = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0] RESET_REPEAT_AFTER = 16'd30;
    localparam logic [CFG_W-1:0] RESET_REPEAT_RATE  = 16'd10;

    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_AFTER = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_RATE  = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_LOAD,
        ST_DRAIN
    } kda_state_t;

    // Control shared by all lanes
    typedef struct packed {
        logic start;   // new frame: latch press/held, load divider
        logic step;    // advance divider by one quotient bit
    } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== src/kda_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kda_in_if
// Request channel carrying one raw switch sample per frame.
// ----------------------------------------------------------------------------
interface kda_in_if;
    logic                      valid;
    logic                      ready;
    logic [kda_pkg::RAW_W-1:0] raw_switches;

    modport source (output valid, output raw_switches, input ready);
    modport sink   (input valid, input raw_switches, output ready);
endinterface

`default_nettype wire

// ===== src/kda_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kda_out_if
// Request channel carrying one switch action.
// ----------------------------------------------------------------------------
interface kda_out_if;
    logic                               valid;
    logic                               ready;
    logic [kda_pkg::SWITCH_INDEX_W-1:0] switch_index;
    logic [kda_pkg::COUNT_W-1:0]        repeat_ordinal;
    logic                               last_action;

    modport source (output valid, output switch_index, output repeat_ordinal,
                    output last_action, input ready);
    modport sink   (input valid, input switch_index, input repeat_ordinal,
                    input last_action, output ready);
endinterface

`default_nettype wire

// ===== src/kda_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kda_lane
// Per-switch core: press frame store and a bit-serial restoring divider
// that works out the auto-repeat ordinal and whether this frame repeats.
// ----------------------------------------------------------------------------
module kda_lane (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire kda_pkg::lane_ctrl_t          ctrl,
    input  wire logic                         press,
    input  wire logic                         held,
    input  wire logic [kda_pkg::COUNT_W-1:0]  frame_count,
    input  wire logic [kda_pkg::CFG_W-1:0]    repeat_after,
    input  wire logic [kda_pkg::CFG_W-1:0]    repeat_rate,
    output logic                              fire,
    output logic [kda_pkg::COUNT_W-1:0]       count
);
    import kda_pkg::*;

    logic [COUNT_W-1:0] press_frame_reg, press_frame_next;
    logic               press_seen_reg, press_seen_next;
    logic               cand_reg, cand_next;
    logic [CFG_W-1:0]   rem_reg, rem_next;
    logic [COUNT_W-1:0] quo_reg, quo_next;

    logic [COUNT_W-1:0] elapsed;
    logic [COUNT_W-1:0] past;
    logic               reached;
    logic [CFG_W:0]     rem_shift;
    logic [CFG_W:0]     rem_sub;
    logic               fits;

    always_comb
    begin
        elapsed   = frame_count - press_frame_reg;
        reached   = elapsed >= {{(COUNT_W-CFG_W){1'b0}}, repeat_after};
        past      = elapsed - {{(COUNT_W-CFG_W){1'b0}}, repeat_after};
        rem_shift = {rem_reg, quo_reg[COUNT_W-1]};
        fits      = rem_shift >= {1'b0, repeat_rate};
        rem_sub   = rem_shift - {1'b0, repeat_rate};
    end

    always_comb
    begin
        press_frame_next = press_frame_reg;
        press_seen_next  = press_seen_reg;
        cand_next        = cand_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        if (ctrl.start)
        begin
            if (press)
                press_frame_next = frame_count;
            press_seen_next = press;
            // a press edge always reports count 0, never a repeat
            cand_next = held && !press && reached;
            rem_next  = '0;
            quo_next  = past;
        end
        else if (ctrl.step)
        begin
            rem_next = fits ? rem_sub[CFG_W-1:0] : rem_shift[CFG_W-1:0];
            quo_next = {quo_reg[COUNT_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_seen_reg <= 1'b0;
            cand_reg       <= 1'b0;
        end
        else
        begin
            press_seen_reg <= press_seen_next;
            cand_reg       <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        press_frame_reg <= press_frame_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
    end

    always_comb
    begin
        fire  = press_seen_reg || (cand_reg && (rem_reg == '0));
        count = press_seen_reg ? '0 : quo_reg;
    end

endmodule

`default_nettype wire

// ===== src/kda_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kda_merge
// Collects lane results and sends actions out in ascending switch order,
// capped per frame, through an output register.
// ----------------------------------------------------------------------------
module kda_merge #(
    parameter int NUM_SWITCHES = 10
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire logic [NUM_SWITCHES-1:0]     fire,
    input  wire logic [kda_pkg::COUNT_W-1:0] count [NUM_SWITCHES],
    kda_out_if.source                        act_out,
    output logic                             busy
);
    import kda_pkg::*;

    localparam int IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

    logic [NUM_SWITCHES-1:0] pending_reg, pending_next;
    logic [COUNT_W-1:0]      count_reg [NUM_SWITCHES];
    logic [RESULT_CNT_W-1:0] sent_reg, sent_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SWITCH_INDEX_W-1:0] out_index_reg;
    logic [COUNT_W-1:0]      out_count_reg;
    logic                    out_last_reg;

    logic [NUM_SWITCHES-1:0] lowest;
    logic [NUM_SWITCHES-1:0] remaining;
    logic [IDX_W-1:0]        sel_idx;
    logic                    emit;
    logic                    last;

    always_comb
    begin
        sel_idx = '0;
        for (int i = NUM_SWITCHES - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
                sel_idx = IDX_W'(i);
        end
        lowest    = pending_reg & (~pending_reg + 1'b1);
        remaining = pending_reg & ~lowest;
        emit      = (|pending_reg) && (!out_valid_reg || act_out.ready);
        last      = (remaining == '0) ||
                    (sent_reg == RESULT_CNT_W'(MAX_RESULTS - 1));
    end

    always_comb
    begin
        pending_next   = pending_reg;
        sent_next      = sent_reg;
        out_valid_next = out_valid_reg;
        if (act_out.ready)
            out_valid_next = 1'b0;
        if (load)
        begin
            pending_next = fire;
            sent_next    = '0;
        end
        else if (emit)
        begin
            pending_next   = last ? '0 : remaining;
            sent_next      = sent_reg + 1'b1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < NUM_SWITCHES; i++)
                count_reg[i] <= count[i];
        end
        if (emit)
        begin
            out_index_reg <= SWITCH_INDEX_W'(sel_idx);
            out_count_reg <= count_reg[sel_idx];
            out_last_reg  <= last;
        end
    end

    assign act_out.valid          = out_valid_reg;
    assign act_out.switch_index   = out_index_reg;
    assign act_out.repeat_ordinal = out_count_reg;
    assign act_out.last_action    = out_last_reg;
    assign busy                   = |pending_reg;

endmodule

`default_nettype wire

// ===== src/key_debounce_autorepeat_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// key_debounce_autorepeat_unit
// Debounced switch bank with auto-repeat: one lane per switch, merged into
// an ordered stream of actions.
// ----------------------------------------------------------------------------
// Output: the first action leaves the output register once the frame request
//   is taken and the 32-step serial divider in each lane has run to its end.
// Frames: a frame yields 0..10 actions; the next frame is taken once each one
//   has gone to the output register, while the last action still waits downstream.
// Reset: history, debounced vector, frame count and control clear; repeat
//   settings return to 30 and 10. Press frame storage is not cleared.
// ----------------------------------------------------------------------------
module key_debounce_autorepeat_unit #(
    parameter int NUM_SWITCHES  = 10,
    parameter int HISTORY_DEPTH = 3
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [kda_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [kda_pkg::CFG_W-1:0]       cfg_data,
    kda_in_if.sink                               sw_in,
    kda_out_if.source                            act_out
);
    import kda_pkg::*;

    kda_state_t state_reg, state_next;

    logic [CFG_W-1:0]        repeat_after_reg, repeat_after_next;
    logic [CFG_W-1:0]        repeat_rate_reg, repeat_rate_next;
    logic [NUM_SWITCHES-1:0] history_reg [HISTORY_DEPTH];
    logic [NUM_SWITCHES-1:0] debounced_reg, debounced_next;
    logic [COUNT_W-1:0]      frame_count_reg, frame_count_next;
    logic [STEP_W-1:0]       step_reg, step_next;

    logic                    accept;
    logic [NUM_SWITCHES-1:0] raw;
    logic [NUM_SWITCHES-1:0] now;
    logic [NUM_SWITCHES-1:0] rising;
    logic [CFG_W-1:0]        rate_eff;
    lane_ctrl_t              lane_ctrl;
    logic                    merge_load;
    logic                    merge_busy;
    logic [NUM_SWITCHES-1:0] lane_fire;
    logic [COUNT_W-1:0]      lane_count [NUM_SWITCHES];

    // Bits of the raw field beyond the switch count are ignored; switches
    // beyond the field width read open.
    always_comb
    begin
        for (int i = 0; i < NUM_SWITCHES; i++)
        begin
            if (i < RAW_W)
                raw[i] = sw_in.raw_switches[i % RAW_W];
            else
                raw[i] = 1'b0;
        end
        now = raw;
        for (int i = 0; i < HISTORY_DEPTH; i++)
            now = now & history_reg[i];
        rising   = now & ~debounced_reg;
        rate_eff = (repeat_rate_reg == '0) ? CFG_W'(1) : repeat_rate_reg;
    end

    // ---- state machine ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (sw_in.valid) state_next = ST_RUN;
            ST_RUN:   if (step_reg == STEP_W'(DIV_STEPS - 1)) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_DRAIN;
            ST_DRAIN: if (!merge_busy) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        sw_in.ready     = 1'b0;
        lane_ctrl.step  = 1'b0;
        merge_load      = 1'b0;
        case (state_reg)
            ST_IDLE:  sw_in.ready    = 1'b1;
            ST_RUN:   lane_ctrl.step = 1'b1;
            ST_LOAD:  merge_load     = 1'b1;
            ST_DRAIN: ;
            default:  ;
        endcase
        accept          = sw_in.valid && sw_in.ready;
        lane_ctrl.start = accept;
    end

    always_comb
    begin
        repeat_after_next = repeat_after_reg;
        repeat_rate_next  = repeat_rate_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_REPEAT_AFTER: repeat_after_next = cfg_data;
                REG_REPEAT_RATE:  repeat_rate_next  = cfg_data;
                default:          ;
            endcase
        end
        debounced_next   = accept ? now : debounced_reg;
        frame_count_next = accept ? frame_count_reg + 1'b1 : frame_count_reg;
        step_next        = lane_ctrl.step ? step_reg + 1'b1 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            repeat_after_reg <= RESET_REPEAT_AFTER;
            repeat_rate_reg  <= RESET_REPEAT_RATE;
            debounced_reg    <= '0;
            frame_count_reg  <= '0;
            step_reg         <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
                history_reg[i] <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            repeat_after_reg <= repeat_after_next;
            repeat_rate_reg  <= repeat_rate_next;
            debounced_reg    <= debounced_next;
            frame_count_reg  <= frame_count_next;
            step_reg         <= step_next;
            if (accept)
            begin
                for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                    history_reg[i] <= history_reg[i + 1];
                history_reg[HISTORY_DEPTH - 1] <= raw;
            end
        end
    end

    // ---- one lane per switch ----
    for (genvar g = 0; g < NUM_SWITCHES; g++)
    begin : g_lane
        kda_lane u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (lane_ctrl),
            .press        (rising[g]),
            .held         (now[g]),
            .frame_count  (frame_count_reg),
            .repeat_after (repeat_after_reg),
            .repeat_rate  (rate_eff),
            .fire         (lane_fire[g]),
            .count        (lane_count[g])
        );
    end

    kda_merge #(
        .NUM_SWITCHES (NUM_SWITCHES)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (merge_load),
        .fire    (lane_fire),
        .count   (lane_count),
        .act_out (act_out),
        .busy    (merge_busy)
    );

endmodule

`default_nettype wire
